// File: rtl/core/spm_pkg.sv
// shared types and constants of the stream pattern matcher
package spm_pkg;

  // parameter defaults
  localparam int MAX_PATTERN_DEF = 16;
  localparam int INDEX_BITS_DEF  = 16;

  // hard limit of pattern bytes the registers can hold
  localparam int PAT_BYTES_MAX = 16;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [1:0] CFG_PATTERN_HIGH   = 2'd2;

  typedef struct packed {
    logic [4:0]                   pattern_length;
    logic [8*PAT_BYTES_MAX-1:0]   pattern;
  } spm_cfg_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic        found;
    logic [15:0] start;
    logic        last;
  } spm_item_t;

  // finished result
  typedef struct packed {
    logic        match_found;
    logic [15:0] match_start;
    logic        first_match_res;
    logic [15:0] match_count;
    logic        last_out;
  } spm_result_t;

endpackage

// File: rtl/core/spm_front.sv
// front part: window shift, pattern compare and text position
module spm_front #(
  parameter int MaxPattern = spm_pkg::MAX_PATTERN_DEF,
  parameter int IndexBits  = spm_pkg::INDEX_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        text_byte_i,
  input  logic              last_i,
  input  spm_pkg::spm_cfg_t cfg_i,
  output logic              push_o,
  output spm_pkg::spm_item_t item_o,
  input  logic              full_i
);

  localparam int PatCap  = (MaxPattern < spm_pkg::PAT_BYTES_MAX) ? MaxPattern
                                                                 : spm_pkg::PAT_BYTES_MAX;
  localparam int WinIdxW = (PatCap > 1) ? $clog2(PatCap) : 1;

  logic [7:0]           win_q [PatCap];
  logic [7:0]           win_next [PatCap];
  logic [IndexBits-1:0] pos_q;
  logic [4:0]           eff_len;
  logic                 cmp_ok;
  logic                 pos_ok;
  logic                 found;
  logic [IndexBits-1:0] start_full;
  logic [IndexBits+15:0] start_ext;
  logic                 accept;

  assign accept     = in_valid_i && !full_i;
  assign in_ready_o = !full_i;
  assign push_o     = accept;

  // clamp length into 1..PatCap
  always_comb begin
    eff_len = cfg_i.pattern_length;
    if (eff_len == 5'd0) eff_len = 5'd1;
    if (eff_len > 5'(PatCap)) eff_len = 5'(PatCap);
  end

  // newest byte enters at entry 0
  always_comb begin
    win_next[0] = text_byte_i;
    for (int i = 1; i < PatCap; i++) begin
      win_next[i] = win_q[i-1];
    end
  end

  // pattern byte k sits len-1-k bytes back
  always_comb begin
    logic [4:0] idx;
    cmp_ok = 1'b1;
    idx    = '0;
    for (int k = 0; k < PatCap; k++) begin
      if (5'(k) < eff_len) begin
        idx = eff_len - 5'd1 - 5'(k);
        if (win_next[idx[WinIdxW-1:0]] != cfg_i.pattern[8*k +: 8]) cmp_ok = 1'b0;
      end
    end
  end

  assign pos_ok     = ({1'b0, pos_q} + (IndexBits+1)'(1)) >= (IndexBits+1)'(eff_len);
  assign found      = cmp_ok && pos_ok;
  assign start_full = found ? (pos_q - IndexBits'(eff_len - 5'd1)) : '0;
  assign start_ext  = {16'd0, start_full};

  assign item_o.found = found;
  assign item_o.start = start_ext[15:0];
  assign item_o.last  = last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PatCap; i++) win_q[i] <= '0;
      pos_q <= '0;
    end else if (accept) begin
      if (last_i) begin
        for (int i = 0; i < PatCap; i++) win_q[i] <= '0;
        pos_q <= '0;
      end else begin
        for (int i = 0; i < PatCap; i++) win_q[i] <= win_next[i];
        if (pos_q != '1) pos_q <= pos_q + IndexBits'(1);
      end
    end
  end

endmodule

// File: rtl/core/spm_queue.sv
// short queue of classified bytes between front and back
module spm_queue #(
  parameter int Depth = spm_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  spm_pkg::spm_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output spm_pkg::spm_item_t item_o,
  output logic               valid_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  spm_pkg::spm_item_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) count_q <= count_q + CntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CntW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0) else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("push lost");

endmodule

// File: rtl/core/spm_back.sv
// back part: match counting, first-match flag and output register
module spm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  spm_pkg::spm_item_t   q_item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spm_pkg::spm_result_t out_o
);

  logic [15:0]          count_q;
  logic [15:0]          count_new;
  logic                 out_valid_q;
  spm_pkg::spm_result_t out_q;

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    count_new = count_q;
    if (q_item_i.found && count_q != 16'hFFFF) count_new = count_q + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        count_q     <= q_item_i.last ? 16'd0 : count_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.match_found     <= q_item_i.found;
      out_q.match_start     <= q_item_i.start;
      out_q.first_match_res <= q_item_i.found && (count_q == 16'd0);
      out_q.match_count     <= count_new;
      out_q.last_out        <= q_item_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/core/stream_pattern_matcher_top.sv
// top level of the stream pattern matcher: configuration registers and stream ports
//
// Streaming naive string matcher. Each input transfer carries one text byte,
// with tlast marking the final byte of a text; each one produces exactly one
// output transfer telling whether the configured pattern (1 to 16 bytes, set
// through the write port) ends at that byte, where it starts, whether it is
// the first match of the text and the saturating match count so far.
// Overlapping matches are all reported. After a tlast byte the window,
// position and count restart for the next text. The block sustains one byte
// per clock while the queue is not full: the front compares the pattern with
// the window in the cycle a byte is taken, a four-entry queue decouples it
// from the back, and the back counts matches into a registered output. A
// result passes from the queue into the output register after its byte is
// taken and transfers when the output side is ready. No clearing pass follows
// reset. Write the configuration only while no text byte is in flight.
module stream_pattern_matcher_top #(
  parameter int MaxPattern = spm_pkg::MAX_PATTERN_DEF,  // window depth, 1..64, capped at 16 bytes
  parameter int IndexBits  = spm_pkg::INDEX_BITS_DEF    // position counter width, 8..32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // text input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // text_byte
  input  logic        s_axis_tlast_i,   // last_of_text
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // from bit 0: match_found, match_start[15:0], first_match_res, match_count[15:0], zero pad
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,   // last_out
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // configuration registers
  logic [4:0]  pattern_length_q;
  logic [63:0] pattern_low_q;
  logic [63:0] pattern_high_q;

  spm_pkg::spm_cfg_t    cfg;
  spm_pkg::spm_item_t   front_item;
  spm_pkg::spm_item_t   queue_item;
  spm_pkg::spm_result_t result;
  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 queue_valid;

  // register index three is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= 5'd1;
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spm_pkg::CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[4:0];
        spm_pkg::CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data_i;
        spm_pkg::CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.pattern_length = pattern_length_q;
  assign cfg.pattern        = {pattern_high_q, pattern_low_q};

  // front: accept a byte, shift the window and classify it
  spm_front #(
    .MaxPattern (MaxPattern),
    .IndexBits  (IndexBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .text_byte_i (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .cfg_i       (cfg),
    .push_o      (push),
    .item_o      (front_item),
    .full_i      (full)
  );

  // queue decouples front stalls from output stalls
  spm_queue #(
    .Depth (spm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .valid_o (queue_valid)
  );

  // back: count matches and hold the result until its transfer
  spm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (queue_valid),
    .q_item_i    (queue_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (result)
  );

  // pack the result fields from bit 0 up
  assign m_axis_tdata_o = {6'd0, result.match_count, result.first_match_res,
                           result.match_start, result.match_found};
  assign m_axis_tlast_o = result.last_out;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the stream pattern matcher with its own window-compare predictor
module testbench;

  localparam int MAX_PAT          = spm_pkg::MAX_PATTERN_DEF;
  localparam int PAT_CAP          = (MAX_PAT < spm_pkg::PAT_BYTES_MAX) ? MAX_PAT
                                                                       : spm_pkg::PAT_BYTES_MAX;
  localparam int POS_BITS         = spm_pkg::INDEX_BITS_DEF;
  localparam int RANDOM_BYTES     = 1100;
  localparam int PHASE_BYTES      = 110;
  localparam int BURST_TEXT_BYTES = 64;  // one text sent at full rate on both sides
  localparam int TAIL_CYCLES      = 8;
  localparam int CYCLE_LIMIT      = 2_000_000;

  // index that decodes to no register, writes there must be ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_TEXT} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [1:0]           reg_index;
    logic [63:0]          reg_value;
    logic [7:0]           text_byte;
    logic                 text_eot;
    logic                 typed;      // report typed into the table instead of predicted
    spm_pkg::spm_result_t report;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // text_byte
  logic        s_axis_tlast_i;   // last_of_text
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // from bit 0: match_found, match_start[15:0], first_match_res, match_count[15:0], zero pad
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;   // last_out
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  stream_pattern_matcher_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // predictor state
  logic [7:0]          window_q [MAX_PAT];
  logic [POS_BITS-1:0] pos_q;
  logic [15:0]         count_q;
  logic [4:0]          len_raw;
  logic [63:0]         pat_low;
  logic [63:0]         pat_high;

  spm_pkg::spm_result_t match_reports_due [$];
  stim_row_t            directed_rows [$];

  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned cycle_count;
  int unsigned text_bytes_sent;
  int unsigned burst_left;
  bit          fast_mode;
  logic [7:0]  sym_a;
  logic [7:0]  sym_b;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_len();
    int unsigned n;
    n = (len_raw == 5'd0) ? 1 : len_raw;
    if (n > PAT_CAP) n = PAT_CAP;
    return n;
  endfunction

  function automatic logic [7:0] pattern_byte(input int unsigned k);
    logic [127:0] pat_all;
    pat_all = {pat_high, pat_low};
    return pat_all[8*k +: 8];
  endfunction

  // shift the byte in, match the pattern, update position and count, clear them at end of text
  function automatic spm_pkg::spm_result_t scan_window(input logic [7:0] b, input logic eot);
    spm_pkg::spm_result_t r;
    int unsigned len;
    int unsigned k;
    logic        hit;
    len = eff_len();
    for (k = MAX_PAT - 1; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = b;
    hit = (int'(pos_q) + 1 >= int'(len));
    if (hit) begin
      for (k = 0; k < len; k++) begin
        if (window_q[len-1-k] != pattern_byte(k)) hit = 1'b0;
      end
    end
    r = '0;
    r.match_found = hit;
    r.last_out    = eot;
    if (hit) begin
      r.match_start     = 16'(int'(pos_q) - int'(len - 1));
      r.first_match_res = (count_q == 16'd0);
      if (count_q != 16'hFFFF) count_q++;
    end
    r.match_count = count_q;
    if (pos_q != '1) pos_q++;
    if (eot) begin
      for (k = 0; k < MAX_PAT; k++) window_q[k] = 8'd0;
      pos_q   = '0;
      count_q = 16'd0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatch_count++;
    $display("result %0d: %s got %0h want %0h", results_checked, what, got, want);
  endtask

  task automatic check_result(input logic [39:0] data, input logic eot);
    spm_pkg::spm_result_t got;
    spm_pkg::spm_result_t want;
    got.match_found     = data[0];
    got.match_start     = data[16:1];
    got.first_match_res = data[17];
    got.match_count     = data[33:18];
    got.last_out        = eot;
    if (match_reports_due.size() == 0) begin
      flag_mismatch("transfer with nothing awaited", 16'd0, 16'd0);
    end else begin
      want = match_reports_due.pop_front();
      if (got.match_found != want.match_found)
        flag_mismatch("match_found", 16'(got.match_found), 16'(want.match_found));
      if (got.match_start != want.match_start)
        flag_mismatch("match_start", got.match_start, want.match_start);
      if (got.first_match_res != want.first_match_res)
        flag_mismatch("first_match_res", 16'(got.first_match_res), 16'(want.first_match_res));
      if (got.match_count != want.match_count)
        flag_mismatch("match_count", got.match_count, want.match_count);
      if (got.last_out != want.last_out)
        flag_mismatch("last_out", 16'(got.last_out), 16'(want.last_out));
    end
    results_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      check_result(m_axis_tdata_o, m_axis_tlast_o);
  end

  // receiver: switches between always ready, light and heavy random stalls, periodic stalls
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    mode_left = 0;
    mode = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (fast_mode) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready_i <= ($urandom_range(0, 9) < 3);
          default: m_axis_tready_i <= ((mode_left % 9) >= 6);
        endcase
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // one text byte: optional gap at a burst boundary, then hold valid until taken
  task automatic drive_byte(input logic [7:0] b, input logic eot, input logic typed,
                            input spm_pkg::spm_result_t known);
    spm_pkg::spm_result_t predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = fast_mode ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eot;
    predicted = scan_window(b, eot);
    match_reports_due.push_back(typed ? known : predicted);
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // sender pauses until every awaited result transfer has come
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (match_reports_due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      spm_pkg::CFG_PATTERN_LENGTH: len_raw  = value[4:0];
      spm_pkg::CFG_PATTERN_LOW:    pat_low  = value;
      spm_pkg::CFG_PATTERN_HIGH:   pat_high = value;
      default: ;
    endcase
  endtask

  task automatic add_write(input logic [1:0] idx, input logic [63:0] value);
    stim_row_t row;
    row = '{kind: ROW_WRITE, reg_index: idx, reg_value: value, text_byte: 8'd0,
            text_eot: 1'b0, typed: 1'b0, report: '0};
    directed_rows.push_back(row);
  endtask

  task automatic add_known(input logic [7:0] b, input logic eot, input logic found,
                           input logic [15:0] start, input logic first,
                           input logic [15:0] count);
    stim_row_t row;
    row = '{kind: ROW_TEXT, reg_index: 2'd0, reg_value: 64'd0, text_byte: b,
            text_eot: eot, typed: 1'b1, report: '0};
    row.report.match_found     = found;
    row.report.match_start     = start;
    row.report.first_match_res = first;
    row.report.match_count     = count;
    row.report.last_out        = eot;
    directed_rows.push_back(row);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic eot);
    stim_row_t row;
    row = '{kind: ROW_TEXT, reg_index: 2'd0, reg_value: 64'd0, text_byte: b,
            text_eot: eot, typed: 1'b0, report: '0};
    directed_rows.push_back(row);
  endtask

  // one text built mostly from pattern copies and prefixes, plus alphabet and noise bytes
  task automatic send_text(input int unsigned n_bytes);
    int unsigned produced;
    int unsigned seg;
    int unsigned pick;
    int unsigned k;
    logic [7:0]  b;
    produced = 0;
    while (produced < n_bytes) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)      seg = eff_len();
      else if (pick < 6) seg = $urandom_range(1, eff_len());
      else               seg = 1;
      for (k = 0; k < seg && produced < n_bytes; k++) begin
        if (pick < 6)      b = pattern_byte(k);
        else if (pick < 9) b = $urandom_range(0, 1) ? sym_a : sym_b;
        else               b = 8'($urandom_range(0, 255));
        produced++;
        drive_byte(b, produced == n_bytes, 1'b0, '0);
        text_bytes_sent++;
        if ($urandom_range(0, 299) == 0) wait_drained();
      end
    end
  endtask

  // new pattern and length while idle; the first phases force the length extremes
  task automatic configure_phase(input int unsigned phase);
    logic [63:0]  raw;
    logic [127:0] pat_all;
    int unsigned  mode;
    int unsigned  k;
    bit           from_alphabet;
    wait_drained();
    sym_a = 8'($urandom_range(0, 255));
    sym_b = 8'($urandom_range(0, 255));
    from_alphabet = ($urandom_range(0, 3) != 0);
    raw = {$urandom, $urandom};
    mode = (phase < 5) ? phase : $urandom_range(0, 6);
    case (mode)
      0: raw[4:0] = 5'd0;
      1: raw[4:0] = 5'd1;
      2: raw[4:0] = 5'd16;
      3: raw[4:0] = 5'd31;
      4: raw[4:0] = 5'($urandom_range(17, 30));
      5: raw[4:0] = 5'($urandom_range(2, 15));
      default: raw[4:0] = 5'($urandom_range(1, 16));
    endcase
    for (k = 0; k < 16; k++) begin
      if (from_alphabet) pat_all[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
      else               pat_all[8*k +: 8] = 8'($urandom_range(0, 255));
    end
    write_reg(spm_pkg::CFG_PATTERN_LENGTH, raw);
    write_reg(spm_pkg::CFG_PATTERN_LOW, pat_all[63:0]);
    write_reg(spm_pkg::CFG_PATTERN_HIGH, pat_all[127:64]);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_end;
    int unsigned n;
    logic [7:0]  fill;
    stim_row_t   row;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'd0;
    s_axis_tlast_i  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = spm_pkg::CFG_PATTERN_LENGTH;
    cfg_data_i      = 64'd0;
    fast_mode       = 1'b0;
    burst_left      = 0;
    mismatch_count  = 0;
    results_checked = 0;
    text_bytes_sent = 0;

    // predictor reset: length 1, pattern all zero, window and counters cleared
    len_raw  = 5'd1;
    pat_low  = 64'd0;
    pat_high = 64'd0;
    pos_q    = '0;
    count_q  = 16'd0;
    for (n = 0; n < MAX_PAT; n++) window_q[n] = 8'd0;

    // reset values: length 1 with a zero pattern byte
    add_known(8'h00, 1'b0, 1'b1, 16'd0, 1'b1, 16'd1);
    add_known(8'hFF, 1'b1, 1'b0, 16'd0, 1'b0, 16'd1);
    add_known(8'h00, 1'b0, 1'b1, 16'd0, 1'b1, 16'd1);
    add_known(8'h00, 1'b1, 1'b1, 16'd1, 1'b0, 16'd2);
    // out-of-range index leaves the pattern alone
    add_write(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_known(8'h00, 1'b1, 1'b1, 16'd0, 1'b1, 16'd1);
    // "ABA" in "ABABA": overlapping matches at 0 and 2
    add_write(spm_pkg::CFG_PATTERN_LENGTH, 64'd3);
    add_write(spm_pkg::CFG_PATTERN_LOW, 64'h0000_0000_0041_4241);
    add_write(spm_pkg::CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    add_known(8'h41, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0);
    add_known(8'h42, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0);
    add_known(8'h41, 1'b0, 1'b1, 16'd0, 1'b1, 16'd1);
    add_known(8'h42, 1'b0, 1'b0, 16'd0, 1'b0, 16'd1);
    add_known(8'h41, 1'b1, 1'b1, 16'd2, 1'b0, 16'd2);
    // short text: the cleared window must not complete the old match
    add_known(8'h42, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0);
    add_known(8'h41, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0);
    // length 0 behaves as 1
    add_write(spm_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
    add_known(8'h41, 1'b1, 1'b1, 16'd0, 1'b1, 16'd1);
    // length 17 clamps to 16 zero bytes, a short text never matches
    add_write(spm_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF1);
    add_write(spm_pkg::CFG_PATTERN_LOW, 64'd0);
    add_write(spm_pkg::CFG_PATTERN_HIGH, 64'd0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        wait_drained();
        write_reg(row.reg_index, row.reg_value);
      end else begin
        drive_byte(row.text_byte, row.text_eot, row.typed, row.report);
      end
    end

    // random phases, each under a fresh pattern and length
    phase = 0;
    while (text_bytes_sent < RANDOM_BYTES) begin
      configure_phase(phase);
      phase_end = text_bytes_sent + PHASE_BYTES;
      while (text_bytes_sent < phase_end)
        send_text(($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(1, 40));
      phase++;
    end

    // one text, mostly of matching bytes, with both sides at full rate
    wait_drained();
    fill = 8'($urandom_range(0, 255));
    write_reg(spm_pkg::CFG_PATTERN_LENGTH, 64'd1);
    write_reg(spm_pkg::CFG_PATTERN_LOW, {$urandom, 24'($urandom_range(0, 16777215)), fill});
    fast_mode = 1'b1;
    for (n = 0; n < BURST_TEXT_BYTES; n++) begin
      if (n < BURST_TEXT_BYTES - 20)
        drive_byte(fill, 1'b0, 1'b0, '0);
      else
        drive_byte(8'($urandom_range(0, 255)), n == BURST_TEXT_BYTES - 1, 1'b0, '0);
    end
    fast_mode = 1'b0;
    // the next text starts from zero again
    send_text(12);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/spm_pkg.sv
rtl/core/spm_front.sv
rtl/core/spm_queue.sv
rtl/core/spm_back.sv
rtl/core/stream_pattern_matcher_top.sv
tb/sv/testbench.sv
